// File: hdl/pe_section_address_translator_defines.svh
// assertion helpers, sampled on clk and switched off while rst_n is low
`ifndef PE_SECTION_ADDRESS_TRANSLATOR_DEFINES_SVH
`define PE_SECTION_ADDRESS_TRANSLATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define PST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PST_NEVER(lbl, cond, msg) \
  `PST_ASSERT(lbl, !(cond), msg)

`else

`define PST_ASSERT(lbl, prop, msg)

`define PST_NEVER(lbl, cond, msg)

`endif

`endif

// File: hdl/pst_pkg.sv
package pst_pkg;

  localparam int MAX_SECTIONS_DEF = 16;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_XLATE  = 2'd2;

  // address kinds
  localparam logic [1:0] KIND_OFF = 2'd0;
  localparam logic [1:0] KIND_RVA = 2'd1;
  localparam logic [1:0] KIND_VA  = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_APPEND,
    OP_PASS,
    OP_FAIL,
    OP_OFF,
    OP_RVA
  } op_t;

  typedef struct packed {
    logic [31:0] vaddr;
    logic [31:0] rawptr;
    logic [31:0] rawsize;
    logic [31:0] vsize;
  } sec_t;

  typedef struct packed {
    op_t         op;
    logic        to_va;
    logic [63:0] addr;
    sec_t        sec;
  } cmd_t;

endpackage

// File: hdl/pst_front.sv
module pst_front import pst_pkg::*; (
  input  logic [1:0]  req_type,
  input  logic [31:0] sec_virtual_addr,
  input  logic [31:0] sec_raw_pointer,
  input  logic [31:0] sec_raw_size,
  input  logic [31:0] sec_virtual_size,
  input  logic [63:0] query_address,
  input  logic [1:0]  source_kind,
  input  logic [1:0]  target_kind,
  input  logic [63:0] image_base,
  output cmd_t        cmd
);

  logic [63:0] rva_of_va;

  assign rva_of_va = query_address - image_base;

  always_comb begin
    cmd.op        = OP_NOP;
    cmd.to_va     = 1'b0;
    cmd.addr      = query_address;
    cmd.sec.vaddr   = sec_virtual_addr;
    cmd.sec.rawptr  = sec_raw_pointer;
    cmd.sec.rawsize = sec_raw_size;
    cmd.sec.vsize   = sec_virtual_size;
    unique case (req_type)
      REQ_CLEAR:  cmd.op = OP_CLEAR;
      REQ_APPEND: cmd.op = OP_APPEND;
      REQ_XLATE: begin
        priority if (source_kind == KIND_BAD || target_kind == KIND_BAD) begin
          cmd.op = OP_FAIL;
        end else if (source_kind == target_kind) begin
          cmd.op = OP_PASS;
        end else if (source_kind == KIND_OFF) begin
          cmd.op    = OP_OFF;
          cmd.to_va = (target_kind == KIND_VA);
        end else if (source_kind == KIND_RVA) begin
          cmd.op    = OP_RVA;
          cmd.to_va = (target_kind == KIND_VA);
        end else if (query_address < image_base) begin
          cmd.op = OP_FAIL;
        end else begin
          // virtual source: rebase, then either hand out the rva or map it to a file offset
          cmd.addr = rva_of_va;
          cmd.op   = (target_kind == KIND_RVA) ? OP_PASS : OP_RVA;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

// File: hdl/pst_queue.sv
module pst_queue import pst_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic head_vld
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign head_vld = (cnt_r != 2'd0);
  assign head     = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/pst_back.sv
`include "pe_section_address_translator_defines.svh"

module pst_back import pst_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_vld,
  output logic        cmd_pop,
  input  logic [63:0] image_base,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_ok,
  output logic [63:0] out_translated,
  output logic        out_table_full
);

  localparam int CW = $clog2(MAX_SECTIONS + 1);
  localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK, S_DONE} state_t;

  state_t      state_r;
  cmd_t        cmd_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [63:0] lowest_r;
  logic [32:0] highest_rel_r;
  logic [32:0] highest_off_r;
  sec_t        mem [MAX_SECTIONS];
  sec_t        rd_data_r;
  logic        rd_vld_r;
  logic        res_ok_r;
  logic [63:0] res_val_r;
  logic        res_full_r;
  logic        add_base_r;
  logic        out_valid_r;
  logic        out_ok_r;
  logic [63:0] out_val_r;
  logic        out_full_r;

  logic        room;
  logic        wr_en;
  logic        issue;
  logic        rd_en;
  logic        slot_free;
  logic [31:0] app_fsize;
  logic [32:0] app_end_rel;
  logic [32:0] app_end_off;
  logic        off_mode;
  logic [31:0] w_base;
  logic [31:0] w_size;
  logic [31:0] w_other;
  logic [32:0] w_end;
  logic [32:0] w_addr;
  logic [32:0] w_diff;
  logic        hit;
  logic [63:0] hit_val;

  assign room      = (cnt_r < CW'(MAX_SECTIONS));
  assign wr_en     = (state_r == S_EXEC) && (cmd_r.op == OP_APPEND) && room;
  assign issue     = (idx_r < cnt_r);
  assign rd_en     = (state_r == S_WALK) && issue;
  assign slot_free = !out_valid_r || out_pop;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_vld;

  // section extent in file falls back to the memory size when there is no raw data
  assign app_fsize   = (cmd_r.sec.rawsize != 32'd0) ? cmd_r.sec.rawsize : cmd_r.sec.vsize;
  assign app_end_rel = {1'b0, cmd_r.sec.vaddr} + {1'b0, app_fsize};
  assign app_end_off = {1'b0, cmd_r.sec.rawptr} + {1'b0, app_fsize};

  always_comb begin
    off_mode = (cmd_r.op == OP_OFF);
    if (off_mode) begin
      w_base  = rd_data_r.rawptr;
      w_size  = (rd_data_r.rawsize != 32'd0) ? rd_data_r.rawsize : rd_data_r.vsize;
      w_other = rd_data_r.vaddr;
    end else begin
      w_base  = rd_data_r.vaddr;
      w_size  = rd_data_r.vsize;
      w_other = rd_data_r.rawptr;
    end
    w_end   = {1'b0, w_base} + {1'b0, w_size};
    w_addr  = cmd_r.addr[32:0];
    // an extent never reaches past 33 bits, so the upper address bits must be clear
    hit     = (cmd_r.addr[63:33] == 31'd0) && (w_addr >= {1'b0, w_base}) && (w_addr < w_end);
    w_diff  = w_addr - {1'b0, w_base};
    hit_val = {31'd0, {1'b0, w_other} + {1'b0, w_diff[31:0]}};
  end

  // section table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IW-1:0]] <= cmd_r.sec;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      idx_r         <= '0;
      lowest_r      <= '1;
      highest_rel_r <= '0;
      highest_off_r <= '0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_vld) begin
            cmd_r   <= cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_ok_r   <= 1'b0;
          res_val_r  <= '0;
          res_full_r <= 1'b0;
          add_base_r <= 1'b0;
          idx_r      <= '0;
          rd_vld_r   <= 1'b0;
          state_r    <= S_DONE;
          unique case (cmd_r.op)
            OP_CLEAR: begin
              cnt_r         <= '0;
              lowest_r      <= '1;
              highest_rel_r <= '0;
              highest_off_r <= '0;
              res_ok_r      <= 1'b1;
            end
            OP_APPEND: begin
              if (room) begin
                cnt_r <= cnt_r + 1'b1;
                if ({32'd0, cmd_r.sec.vaddr} < lowest_r) begin
                  lowest_r <= {32'd0, cmd_r.sec.vaddr};
                end
                if (app_end_rel > highest_rel_r) begin
                  highest_rel_r <= app_end_rel;
                end
                if (app_end_off > highest_off_r) begin
                  highest_off_r <= app_end_off;
                end
                res_ok_r <= 1'b1;
              end else begin
                res_full_r <= 1'b1;
              end
            end
            OP_PASS: begin
              res_ok_r  <= 1'b1;
              res_val_r <= cmd_r.addr;
            end
            OP_RVA: begin
              priority if (cmd_r.addr < lowest_r) begin
                // below every section the address comes back unchanged
                res_ok_r  <= 1'b1;
                res_val_r <= cmd_r.addr;
              end else if (cmd_r.addr >= {31'd0, highest_rel_r}) begin
                res_ok_r <= 1'b0;
              end else if (cmd_r.to_va) begin
                res_ok_r   <= 1'b1;
                res_val_r  <= cmd_r.addr;
                add_base_r <= 1'b1;
              end else begin
                state_r <= S_WALK;
              end
            end
            OP_OFF: begin
              if (cmd_r.addr < {31'd0, highest_off_r}) begin
                add_base_r <= cmd_r.to_va;
                state_r    <= S_WALK;
              end
            end
            default: res_ok_r <= 1'b0;
          endcase
        end
        S_WALK: begin
          // one section read per cycle, judged the cycle after its read
          rd_vld_r <= issue;
          if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
          if (rd_vld_r && hit) begin
            res_ok_r  <= 1'b1;
            res_val_r <= hit_val;
            rd_vld_r  <= 1'b0;
            state_r   <= S_DONE;
          end else if (!issue) begin
            add_base_r <= 1'b0;
            rd_vld_r   <= 1'b0;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= res_ok_r;
            out_val_r   <= add_base_r ? (image_base + res_val_r) : res_val_r;
            out_full_r  <= res_full_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_translated = out_val_r;
  assign out_table_full = out_full_r;

  `PST_NEVER(a_cnt_in_range, cnt_r > CW'(MAX_SECTIONS), "section count beyond capacity")
  `PST_ASSERT(a_rd_only_in_walk, rd_vld_r |-> (state_r == S_WALK), "table read outside walk")
  `PST_ASSERT(a_idx_le_cnt, (state_r == S_WALK) |-> (idx_r <= cnt_r), "walk index past count")
  `PST_ASSERT(a_done_loads_out, (state_r == S_DONE && slot_free) |=> out_valid_r, "beat lost")
  `PST_ASSERT(a_fail_is_zero, (out_valid_r && !out_ok_r) |-> (out_val_r == 64'd0), "fail not zero")

endmodule

// File: hdl/pe_section_address_translator.sv
// section address translator
// input channel: in_push / in_full, one beat per request (clear table, append
// section, translate address); a beat is taken when in_push is high and in_full low.
// result channel: out_empty / out_pop, exactly one result beat per request, in
// request order; a beat leaves when out_pop is high and out_empty low.
// cfg channel: cfg_valid / cfg_ready writes image_base; cfg_ready is always high,
// writes are expected only while no request is in flight.
// a two-entry queue sits between the decoder and the table engine, so input keeps
// flowing while the engine works or the result waits to be taken.
// steps: a request waits in the queue, then the engine takes it through IDLE, EXEC
// and DONE; a table walk adds WALK between EXEC and DONE, which visits the stored
// sections in order until one holds the address, one per cycle from the single-port
// section memory; the engine takes a new request only once the last result is loaded.
// if out_pop stays low the finished result holds, the engine stalls at its end and
// the queue then fills and raises in_full.
// reset clears the table, bounds, image_base and both channels; no clearing pass.
module pe_section_address_translator import pst_pkg::*; #(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_sec_virtual_addr,
  input  logic [31:0] in_sec_raw_pointer,
  input  logic [31:0] in_sec_raw_size,
  input  logic [31:0] in_sec_virtual_size,
  input  logic [63:0] in_query_address,
  input  logic [1:0]  in_source_kind,
  input  logic [1:0]  in_target_kind,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_ok,
  output logic [63:0] out_translated,
  output logic        out_table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_image_base
);

  logic [63:0] image_base_r;
  cmd_t        dec_cmd;
  cmd_t        q_head;
  logic        q_vld;
  logic        q_pop;
  logic        q_full;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      image_base_r <= cfg_image_base;
    end
  end

  pst_front u_front (
    .req_type         (in_req_type),
    .sec_virtual_addr (in_sec_virtual_addr),
    .sec_raw_pointer  (in_sec_raw_pointer),
    .sec_raw_size     (in_sec_raw_size),
    .sec_virtual_size (in_sec_virtual_size),
    .query_address    (in_query_address),
    .source_kind      (in_source_kind),
    .target_kind      (in_target_kind),
    .image_base       (image_base_r),
    .cmd              (dec_cmd)
  );

  pst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push && !q_full),
    .push_data (dec_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .head_vld  (q_vld)
  );

  pst_back #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (q_head),
    .cmd_vld        (q_vld),
    .cmd_pop        (q_pop),
    .image_base     (image_base_r),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_ok         (out_ok),
    .out_translated (out_translated),
    .out_table_full (out_table_full)
  );

endmodule
